### design/cda_pkg.sv
// Shared types, constants and calendar helper functions for the date adder.
package cda_pkg;

  // Leap pattern repeats every 400 years.
  localparam int unsigned YearCycle   = 400;
  localparam int unsigned YearCycleW  = 9;
  localparam int unsigned RemW        = 17;
  localparam int unsigned ModSteps    = 8;
  localparam int unsigned StepW       = 3;
  localparam int unsigned MonthsPerYr = 12;
  localparam int unsigned YearMax     = 65535;

  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthDec = 4'(MonthsPerYr);
  localparam logic [4:0] DayLast  = 5'd31;
  localparam logic [4:0] DayFeb   = 5'd28;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CHECK,
    ST_WALK,
    ST_OUT
  } state_e;

  // Leap test on the year reduced modulo 400.
  function automatic logic leap_of(input logic [YearCycleW-1:0] ymod);
    logic div4;
    logic cent;
    begin
      div4 = (ymod[1:0] == 2'b00);
      cent = (ymod == 9'd100) || (ymod == 9'd200) || (ymod == 9'd300);
      leap_of = div4 && !cent;
    end
  endfunction

  // Length of a month; zero for a month code outside the calendar.
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    begin
      case (month)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DayLast;
        4'd4, 4'd6, 4'd9, 4'd11:                    len = DayLast - 5'd1;
        MonthFeb:                                   len = DayFeb + {4'd0, leap};
        default:                                    len = 5'd0;
      endcase
      month_len = len;
    end
  endfunction

endpackage

### design/calendar_date_add_days.sv
// Gregorian date plus signed day offset, walked one month per cycle on a shared adder.
// The month walk on the shared adder dominates: the year is first reduced modulo 400,
// then the date is checked, then the months are crossed one by one.
// One item at a time; the next item is taken while a finished result waits.
// Reset (rst_ni low, asynchronous) returns to idle and drops any pending result beat.
module calendar_date_add_days (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] start_day, [8:5] start_month, [24:9] start_year, [40:25] day_offset, [47:41] zero
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] end_day, [8:5] end_month, [24:9] end_year, [31:25] zero
  output logic [31:0] m_axis_tdata,
  // [0] date_invalid, [1] year_out_of_range
  output logic [1:0]  m_axis_tuser
);

  cda_pkg::state_e state_q, state_d;

  logic [4:0]                      day_q, day_d;
  logic [3:0]                      month_q, month_d;
  logic signed [17:0]              yr_q, yr_d;
  logic [cda_pkg::RemW-1:0]        rem_q, rem_d;
  logic [cda_pkg::StepW-1:0]       step_q, step_d;
  logic signed [16:0]              t_q, t_d;
  logic                            inv_q, inv_d;

  logic        m_valid_q;
  logic [4:0]  out_day_q;
  logic [3:0]  out_month_q;
  logic [15:0] out_year_q;
  logic        out_inv_q;
  logic        out_oor_q;

  logic [cda_pkg::YearCycleW-1:0] ymod, ymod_inc, ymod_dec;
  logic        leap_cur, leap_prev, walk_fwd, walk_done, date_ok, out_free, load_out;
  logic [3:0]  prev_month;
  logic [4:0]  len_cur, len_prev;
  logic signed [17:0] add_a, add_b, add_sum;
  logic [17:0] sub_val;

  // Calendar helpers around the year residue
  assign ymod      = rem_q[cda_pkg::YearCycleW-1:0];
  assign ymod_inc  = (ymod == 9'(cda_pkg::YearCycle - 1)) ? '0 : ymod + 9'd1;
  assign ymod_dec  = (ymod == '0) ? 9'(cda_pkg::YearCycle - 1) : ymod - 9'd1;
  assign leap_cur  = cda_pkg::leap_of(ymod);
  assign leap_prev = cda_pkg::leap_of(ymod_dec);
  assign prev_month = (month_q == cda_pkg::MonthJan) ? cda_pkg::MonthDec : month_q - 4'd1;
  assign len_cur   = cda_pkg::month_len(month_q, leap_cur);
  assign len_prev  = cda_pkg::month_len(prev_month,
                       (month_q == cda_pkg::MonthJan) ? leap_prev : leap_cur);
  assign walk_fwd  = !t_q[16];
  assign sub_val   = 18'(cda_pkg::YearCycle) << step_q;

  // Shared adder: operands picked by the sequencer state
  always_comb begin
    add_a = '0;
    add_b = '0;
    case (state_q)
      cda_pkg::ST_MOD: begin
        add_a = {1'b0, rem_q};
        add_b = -$signed(sub_val);
      end
      cda_pkg::ST_CHECK: begin
        add_a = {t_q[16], t_q};
        add_b = $signed({13'd0, day_q - 5'd1});
      end
      cda_pkg::ST_WALK: begin
        add_a = {t_q[16], t_q};
        add_b = walk_fwd ? -$signed({13'd0, len_cur}) : $signed({13'd0, len_prev});
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end
  assign add_sum = add_a + add_b;

  assign walk_done = walk_fwd && add_sum[17];
  assign date_ok   = (month_q >= cda_pkg::MonthJan) && (month_q <= cda_pkg::MonthDec) &&
                     (day_q != 5'd0) && (day_q <= len_cur);
  assign out_free  = !m_valid_q || m_axis_tready;
  assign load_out  = (state_q == cda_pkg::ST_OUT) && out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cda_pkg::ST_IDLE:  if (s_axis_tvalid) state_d = cda_pkg::ST_MOD;
      cda_pkg::ST_MOD:   if (step_q == '0) state_d = cda_pkg::ST_CHECK;
      cda_pkg::ST_CHECK: state_d = date_ok ? cda_pkg::ST_WALK : cda_pkg::ST_OUT;
      cda_pkg::ST_WALK:  if (walk_done) state_d = cda_pkg::ST_OUT;
      cda_pkg::ST_OUT:   if (out_free) state_d = cda_pkg::ST_IDLE;
      default:           state_d = cda_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates per state
  always_comb begin
    day_d   = day_q;
    month_d = month_q;
    yr_d    = yr_q;
    rem_d   = rem_q;
    step_d  = step_q;
    t_d     = t_q;
    inv_d   = inv_q;
    case (state_q)
      cda_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          day_d   = s_axis_tdata[4:0];
          month_d = s_axis_tdata[8:5];
          yr_d    = $signed({2'b00, s_axis_tdata[24:9]});
          rem_d   = {1'b0, s_axis_tdata[24:9]};
          t_d     = $signed({s_axis_tdata[40], s_axis_tdata[40:25]});
          step_d  = 3'(cda_pkg::ModSteps - 1);
          inv_d   = 1'b0;
        end
      end
      cda_pkg::ST_MOD: begin
        if (!add_sum[17]) rem_d = add_sum[cda_pkg::RemW-1:0];
        step_d = step_q - 3'd1;
      end
      cda_pkg::ST_CHECK: begin
        inv_d = !date_ok;
        t_d   = add_sum[16:0];
      end
      cda_pkg::ST_WALK: begin
        if (walk_fwd) begin
          // advance one month while the day index passes its length
          if (!add_sum[17]) begin
            t_d = add_sum[16:0];
            if (month_q == cda_pkg::MonthDec) begin
              month_d = cda_pkg::MonthJan;
              yr_d    = yr_q + 18'sd1;
              rem_d   = {8'd0, ymod_inc};
            end else begin
              month_d = month_q + 4'd1;
            end
          end
        end else begin
          // step back one month and add its length
          t_d     = add_sum[16:0];
          month_d = prev_month;
          if (month_q == cda_pkg::MonthJan) begin
            yr_d  = yr_q - 18'sd1;
            rem_d = {8'd0, ymod_dec};
          end
        end
      end
      default: begin
        day_d = day_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cda_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    day_q   <= day_d;
    month_q <= month_d;
    yr_q    <= yr_d;
    rem_q   <= rem_d;
    step_q  <= step_d;
    t_q     <= t_d;
    inv_q   <= inv_d;
  end

  // Result beat valid: set on load, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // Result payload with echo and year saturation
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_inv_q <= inv_q;
      if (inv_q) begin
        out_day_q   <= day_q;
        out_month_q <= month_q;
        out_year_q  <= yr_q[15:0];
        out_oor_q   <= 1'b0;
      end else if (yr_q < 0) begin
        out_day_q   <= 5'd1;
        out_month_q <= cda_pkg::MonthJan;
        out_year_q  <= '0;
        out_oor_q   <= 1'b1;
      end else if (yr_q > 18'(cda_pkg::YearMax)) begin
        out_day_q   <= cda_pkg::DayLast;
        out_month_q <= cda_pkg::MonthDec;
        out_year_q  <= 16'(cda_pkg::YearMax);
        out_oor_q   <= 1'b1;
      end else begin
        out_day_q   <= t_q[4:0] + 5'd1;
        out_month_q <= month_q;
        out_year_q  <= yr_q[15:0];
        out_oor_q   <= 1'b0;
      end
    end
  end

  assign s_axis_tready = (state_q == cda_pkg::ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, out_year_q, out_month_q, out_day_q};
  assign m_axis_tuser  = {out_oor_q, out_inv_q};

  // Checks on sequencer and result consistency
  a_accept_to_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q == cda_pkg::ST_MOD)
    else $error("accepted beat did not start the year reduction");

  a_residue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cda_pkg::ST_WALK |-> rem_q < 17'(cda_pkg::YearCycle))
    else $error("year residue out of range during walk");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("invalid and out-of-range flags both set");

  a_valid_result_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      (m_axis_tdata[8:5] >= cda_pkg::MonthJan) && (m_axis_tdata[8:5] <= cda_pkg::MonthDec) &&
      (m_axis_tdata[4:0] != 5'd0))
    else $error("result date outside calendar");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> m_axis_tvalid)
    else $error("loaded result not presented");

endmodule
